// ----- src/twin_prime_sieve_counter_core_defines.svh -----
// assertion macros shared by the sieve counter modules
`ifndef TWIN_PRIME_SIEVE_COUNTER_CORE_DEFINES_SVH
`define TWIN_PRIME_SIEVE_COUNTER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked on every rising edge, quiet while reset is asserted
`define TPSC_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("tpsc check failed");
// same check, also evaluated during reset
`define TPSC_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("tpsc check failed");
`else
`define TPSC_ASSERT(label, prop)
`define TPSC_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ----- src/tpsc_pkg.sv -----
// command and status types between the sieve controller and datapath
package tpsc_pkg;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;
	localparam logic [15:0] SMALLEST_PRIME = 16'd2;

	typedef struct packed {
		logic load;       // take a new limit beat, reset counts
		logic clr_step;   // clear one bitmap entry after reset
		logic sq;         // square the current prime
		logic mark_init;  // start marking at p*p
		logic mark_step;  // mark one multiple
		logic srch_next;  // candidate was composite, try the next
		logic take_prime; // candidate is the next prime
		logic scan_init;  // start the counting scan at 2
		logic scan_step;  // read and clear one entry of the scan
		logic finish;     // load the result register
	} cmd_t;

	typedef struct packed {
		logic small_n;   // incoming limit below two
		logic clr_last;  // clear pointer at the last entry
		logic sq_le_n;   // p*p within the limit
		logic next_le_n; // next multiple within the limit
		logic m_gt_n;    // search pointer beyond the limit
		logic m_eq_n;    // scan pointer at the limit
		logic rd_bit;    // registered bitmap read data
		logic out_free;  // result register can take a beat
	} sts_t;

endpackage

// ----- src/tpsc_map.sv -----
// composite bitmap: one write port, one registered read port
module tpsc_map #(
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic                     wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic                     rdata
);

	logic map_q [DEPTH];
	logic rdata_q;

	// read returns the old entry when the same address is written
	always_ff @(posedge clk) begin
		if (we) begin
			map_q[waddr] <= wdata;
		end
		rdata_q <= map_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- src/tpsc_dp.sv -----
// sieve datapath: limit, prime, pointer, squarer, counters, result register
module tpsc_dp #(
	parameter int MAX_N = 65536
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  tpsc_pkg::cmd_t           cmd,
	output tpsc_pkg::sts_t           sts,
	input  logic [15:0]              limit_n,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [15:0]              twin_count,
	output logic [15:0]              prime_count,
	output logic                     map_we,
	output logic [$clog2(MAX_N)-1:0] map_waddr,
	output logic                     map_wdata,
	output logic [$clog2(MAX_N)-1:0] map_raddr,
	input  logic                     map_rdata
);
	import tpsc_pkg::*;

	localparam int AW = $clog2(MAX_N);
	localparam int LW = (AW > 16) ? AW : 16;
	localparam logic [LW-1:0] NMAX_W = LW'(MAX_N - 1);
	localparam logic [AW:0] LAST_ADDR = (AW + 1)'(MAX_N - 1);

	logic [AW-1:0]   n_q;
	logic [AW-1:0]   p_q;
	logic [AW:0]     m_q;
	logic [2*AW-1:0] sq_q;
	logic [15:0]     primes_q;
	logic [15:0]     twins_q;
	logic [AW-1:0]   prev_q;
	logic            prev_valid_q;
	logic            v_s1;
	logic [AW-1:0]   idx_s1;
	logic            out_valid_q;
	logic [15:0]     out_twins_q;
	logic [15:0]     out_primes_q;

	logic [LW-1:0]   lim_w;
	logic [AW-1:0]   n_next;
	logic [AW:0]     m_plus_p;
	logic            is_prime;
	logic            is_twin;

	assign lim_w    = LW'(limit_n);
	assign n_next   = (lim_w > NMAX_W) ? NMAX_W[AW-1:0] : lim_w[AW-1:0];
	assign m_plus_p = m_q + {1'b0, p_q};
	assign is_prime = v_s1 && !map_rdata;
	assign is_twin  = prev_valid_q && (({1'b0, prev_q} + (AW + 1)'(2)) == {1'b0, idx_s1});

	always_comb begin
		sts.small_n   = limit_n < SMALLEST_PRIME;
		sts.clr_last  = m_q == LAST_ADDR;
		sts.sq_le_n   = sq_q <= (2 * AW)'(n_q);
		sts.next_le_n = m_plus_p <= {1'b0, n_q};
		sts.m_gt_n    = m_q > {1'b0, n_q};
		sts.m_eq_n    = m_q == {1'b0, n_q};
		sts.rd_bit    = map_rdata;
		sts.out_free  = !out_valid_q || !out_stall;
	end

	assign map_we    = cmd.clr_step || cmd.mark_step || cmd.scan_step;
	assign map_wdata = cmd.mark_step;
	assign map_waddr = m_q[AW-1:0];
	assign map_raddr = m_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q          <= '0;
			v_s1         <= 1'b0;
			out_valid_q  <= 1'b0;
			prev_valid_q <= 1'b0;
		end else begin
			v_s1 <= cmd.scan_step;
			if (cmd.load) begin
				prev_valid_q <= 1'b0;
			end else if (is_prime) begin
				prev_valid_q <= 1'b1;
			end
			if (cmd.clr_step || cmd.srch_next || cmd.scan_step) begin
				m_q <= m_q + (AW + 1)'(1);
			end else if (cmd.mark_init) begin
				m_q <= sq_q[AW:0];
			end else if (cmd.mark_step) begin
				// last multiple marked: go on to look for the next prime
				m_q <= sts.next_le_n ? m_plus_p : ({1'b0, p_q} + (AW + 1)'(1));
			end else if (cmd.scan_init) begin
				m_q <= (AW + 1)'(2);
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= m_q[AW-1:0];
		if (cmd.load) begin
			n_q      <= n_next;
			p_q      <= AW'(2);
			primes_q <= '0;
			twins_q  <= '0;
		end else begin
			if (cmd.take_prime) begin
				p_q <= m_q[AW-1:0];
			end
			if (is_prime) begin
				if (primes_q != COUNT_MAX) begin
					primes_q <= primes_q + 16'd1;
				end
				if (is_twin && twins_q != COUNT_MAX) begin
					twins_q <= twins_q + 16'd1;
				end
				prev_q <= idx_s1;
			end
		end
		if (cmd.sq) begin
			sq_q <= (2 * AW)'(p_q) * (2 * AW)'(p_q);
		end
		if (cmd.finish) begin
			out_twins_q  <= twins_q;
			out_primes_q <= primes_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign twin_count  = out_twins_q;
	assign prime_count = out_primes_q;

	`include "twin_prime_sieve_counter_core_defines.svh"

	`TPSC_ASSERT(a_mark_in_range, cmd.mark_step |-> (m_q <= {1'b0, n_q}))
	`TPSC_ASSERT(a_new_prime_unmarked, cmd.take_prime |-> !map_rdata)
	`TPSC_ASSERT(a_twins_le_primes, out_valid_q |-> (out_twins_q <= out_primes_q))

endmodule

// ----- src/tpsc_ctrl.sv -----
// sieve controller: clear sweep, sieve, next-prime search, counting scan
module tpsc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  tpsc_pkg::sts_t sts,
	output tpsc_pkg::cmd_t cmd
);
	import tpsc_pkg::*;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_SQ,
		ST_CHK,
		ST_MARK,
		ST_SRCH,
		ST_SWAIT,
		ST_SCAN,
		ST_DRAIN,
		ST_FIN
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = state_q != ST_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.small_n ? ST_FIN : ST_SQ;
				end
			end
			ST_SQ: begin
				cmd.sq  = 1'b1;
				state_d = ST_CHK;
			end
			ST_CHK: begin
				if (sts.sq_le_n) begin
					cmd.mark_init = 1'b1;
					state_d       = ST_MARK;
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = ST_SCAN;
				end
			end
			ST_MARK: begin
				cmd.mark_step = 1'b1;
				if (!sts.next_le_n) begin
					state_d = ST_SRCH;
				end
			end
			ST_SRCH: begin
				// read of the candidate is issued here, data comes back next cycle
				if (sts.m_gt_n) begin
					cmd.scan_init = 1'b1;
					state_d       = ST_SCAN;
				end else begin
					state_d = ST_SWAIT;
				end
			end
			ST_SWAIT: begin
				if (sts.rd_bit) begin
					cmd.srch_next = 1'b1;
					state_d       = ST_SRCH;
				end else begin
					cmd.take_prime = 1'b1;
					state_d        = ST_SQ;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.m_eq_n) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last scan read is counted at this edge
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	`include "twin_prime_sieve_counter_core_defines.svh"

	`TPSC_ASSERT(a_one_write, $onehot0({cmd.clr_step, cmd.mark_step, cmd.scan_step}))
	`TPSC_ASSERT(a_swait_after_srch, (state_q == ST_SWAIT) |-> ($past(state_q) == ST_SRCH))
	`TPSC_ASSERT(a_drain_after_scan, (state_q == ST_DRAIN) |-> ($past(state_q) == ST_SCAN))

endmodule

// ----- src/twin_prime_sieve_counter_core.sv -----
// one limit is processed at a time
// the single-write-port bitmap sets the pace: one mark or scan entry a cycle
// a limit below two skips the sieve and the scan and gives counts of zero
// after reset a clearing pass over all MAX_N entries runs with in_stall high; each scan clears what it read
// reset returns the controller to the clearing pass and empties the result register
module twin_prime_sieve_counter_core #(
	parameter int MAX_N = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] limit_n,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] twin_count,
	output logic [15:0] prime_count
);
	import tpsc_pkg::*;

	localparam int AW = $clog2(MAX_N);

	cmd_t          cmd;
	sts_t          sts;
	logic          map_we;
	logic [AW-1:0] map_waddr;
	logic          map_wdata;
	logic [AW-1:0] map_raddr;
	logic          map_rdata;

	tpsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	tpsc_dp #(
		.MAX_N (MAX_N)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.limit_n     (limit_n),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.twin_count  (twin_count),
		.prime_count (prime_count),
		.map_we      (map_we),
		.map_waddr   (map_waddr),
		.map_wdata   (map_wdata),
		.map_raddr   (map_raddr),
		.map_rdata   (map_rdata)
	);

	tpsc_map #(
		.DEPTH (MAX_N)
	) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

endmodule
